@@ design/msled_pkg.sv @@
// ----------------------------------------------------------------------------
// LED slot controller package
// Command codes, internal command record, slot modes and sequencer states.
// ----------------------------------------------------------------------------
package msled_pkg;

	// Input function codes
	localparam logic [2:0] FUNC_SET   = 3'd0;
	localparam logic [2:0] FUNC_ONCE  = 3'd1;
	localparam logic [2:0] FUNC_TWICE = 3'd2;
	localparam logic [2:0] FUNC_CONT  = 3'd3;
	localparam logic [2:0] FUNC_TICK  = 3'd4;
	localparam logic [2:0] FUNC_ANIM  = 3'd5;

	// Slot indexes are carried wide enough for the largest slot count.
	localparam int SLOT_IDX_W = 4;
	localparam int TIMER_W    = 27;
	localparam int THR_W      = 26;
	localparam int THR_SCALE  = 1000;
	localparam int BLINK_MS_RESET = 100;

	typedef enum logic [1:0] {
		OP_SET,
		OP_BLINK,
		OP_TICK,
		OP_ANIM
	} op_t;

	typedef enum logic [1:0] {
		MODE_SOLID,
		MODE_ONCE,
		MODE_TWICE,
		MODE_CONT
	} mode_t;

	typedef enum logic [1:0] {
		KIND_DRAW,
		KIND_PUSH,
		KIND_STOP,
		KIND_START
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STOP,
		ST_DRAW,
		ST_PUSH,
		ST_START,
		ST_TICK,
		ST_TPUSH,
		ST_TFIN
	} bstate_t;

	typedef struct packed {
		op_t                   op;
		mode_t                 mode;
		logic [SLOT_IDX_W-1:0] lo;
		logic [SLOT_IDX_W-1:0] hi;
		logic [31:0]           color;
		logic [19:0]           us;
	} cmd_t;

endpackage

@@ design/msled_if.sv @@
// ----------------------------------------------------------------------------
// LED slot controller channels
// Valid/ready channels for command items and for result items.
// ----------------------------------------------------------------------------
interface msled_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [2:0]  slot;
	logic        all_slots;
	logic [31:0] color;
	logic [19:0] elapsed_us;

	modport source (output valid, func, slot, all_slots, color, elapsed_us, input ready);
	modport sink (input valid, func, slot, all_slots, color, elapsed_us, output ready);
endinterface

interface msled_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [2:0]  pixel_slot;
	logic [31:0] pixel_color;
	logic        last;

	modport source (output valid, kind, pixel_slot, pixel_color, last, input ready);
	modport sink (input valid, kind, pixel_slot, pixel_color, last, output ready);
endinterface

@@ design/msled_front.sv @@
// ----------------------------------------------------------------------------
// LED slot controller front end
// Accepts command items, decodes them into internal commands and drops
// unused codes and out-of-range slots.
// ----------------------------------------------------------------------------
module msled_front import msled_pkg::*; #(
	parameter int NUM_SLOTS = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	msled_item_if.sink  item,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);

	localparam int CNT_W = SLOT_IDX_W + 1;
	localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(NUM_SLOTS - 1);
	localparam logic [CNT_W-1:0] NSLOTS = CNT_W'(NUM_SLOTS);

	logic                  valid_s1;
	cmd_t                  cmd_s1;
	logic                  keep;
	logic                  in_range;
	logic                  slot_ok;
	logic [SLOT_IDX_W-1:0] sel_lo;
	logic [SLOT_IDX_W-1:0] sel_hi;
	cmd_t                  cls;

	always_comb begin
		in_range = CNT_W'(item.slot) < NSLOTS;
		slot_ok  = item.all_slots || in_range;
		sel_lo   = item.all_slots ? '0 : SLOT_IDX_W'(item.slot);
		sel_hi   = item.all_slots ? LAST_IDX : SLOT_IDX_W'(item.slot);
		keep      = 1'b0;
		cls.op    = OP_SET;
		cls.mode  = MODE_ONCE;
		cls.lo    = '0;
		cls.hi    = LAST_IDX;
		cls.color = item.color;
		cls.us    = item.elapsed_us;
		case (item.func)
			FUNC_SET: begin
				keep   = slot_ok;
				cls.lo = sel_lo;
				cls.hi = sel_hi;
			end
			FUNC_ONCE: begin
				keep   = slot_ok;
				cls.op = OP_BLINK;
				cls.lo = sel_lo;
				cls.hi = sel_hi;
			end
			FUNC_TWICE: begin
				keep     = slot_ok;
				cls.op   = OP_BLINK;
				cls.mode = MODE_TWICE;
				cls.lo   = sel_lo;
				cls.hi   = sel_hi;
			end
			FUNC_CONT: begin
				keep     = slot_ok;
				cls.op   = OP_BLINK;
				cls.mode = MODE_CONT;
				cls.lo   = sel_lo;
				cls.hi   = sel_hi;
			end
			FUNC_TICK: begin
				keep   = 1'b1;
				cls.op = OP_TICK;
			end
			FUNC_ANIM: begin
				keep   = 1'b1;
				cls.op = OP_ANIM;
			end
			default: keep = 1'b0;
		endcase
	end

	assign item.ready = !valid_s1 || cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= keep;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_s1 <= cls;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

endmodule

@@ design/msled_cmdq.sv @@
// ----------------------------------------------------------------------------
// LED slot controller command queue
// Short FIFO that decouples the decoder from the slot sequencer.
// ----------------------------------------------------------------------------
module msled_cmdq import msled_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int DEPTH = 2;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	cmd_t          entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("command queue holds more entries than its depth");

	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("command queue lost a pushed command");

endmodule

@@ design/msled_back.sv @@
// ----------------------------------------------------------------------------
// LED slot controller sequencer
// Holds the slot state, walks the slots of each command and issues the
// resulting draw, push and animation events through an output register.
// ----------------------------------------------------------------------------
module msled_back import msled_pkg::*; #(
	parameter int NUM_SLOTS = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  cmd_t          q_cmd,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	msled_result_if.source result
);

	localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int TSW = TIMER_W + 1;
	localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(NUM_SLOTS - 1);

	typedef struct packed {
		logic               we_mode;
		mode_t              mode;
		logic               we_phase;
		logic               phase;
		logic               we_timer;
		logic [TIMER_W-1:0] timer;
		logic               we_rest;
		logic               we_blnk;
	} slot_wr_t;

	bstate_t               state_q, state_d;
	cmd_t                  cmd_q;
	logic [SLOT_IDX_W-1:0] idx_q;
	logic                  need_push_q;
	logic                  toggled_q;
	logic                  anim_q;
	logic                  pend_q;
	logic [THR_W-1:0]      thr_q;

	mode_t                 mode_q  [NUM_SLOTS];
	logic                  phase_q [NUM_SLOTS];
	logic [TIMER_W-1:0]    timer_q [NUM_SLOTS];
	logic [31:0]           rest_q  [NUM_SLOTS];
	logic [31:0]           blnk_q  [NUM_SLOTS];

	logic                  res_valid_q;
	kind_t                 res_kind_q;
	logic [2:0]            res_slot_q;
	logic [31:0]           res_color_q;
	logic                  res_last_q;

	logic [SW-1:0]         cur;
	logic                  last_slot;
	logic                  emit_ok;
	logic                  pop;
	logic                  emit;
	kind_t                 e_kind;
	logic                  e_draw;
	logic [31:0]           e_color;
	logic                  e_last;
	logic                  adv;
	logic                  tick_adv;
	logic                  np_load;
	logic                  np_val;
	logic                  clr_anim;
	logic                  set_anim;
	logic                  set_pend;
	logic                  clr_pend;
	logic                  set_tog;
	slot_wr_t              wr;
	logic [TSW-1:0]        t_sum;
	logic [TIMER_W-1:0]    t_sat;
	logic                  hit;

	assign cur       = idx_q[SW-1:0];
	assign last_slot = idx_q == cmd_q.hi;
	assign emit_ok   = !res_valid_q || result.ready;
	assign pop       = q_valid && q_ready;

	// The accumulator saturates instead of wrapping.
	assign t_sum = {1'b0, timer_q[cur]} + TSW'(cmd_q.us);
	assign t_sat = t_sum[TIMER_W] ? '1 : t_sum[TIMER_W-1:0];
	assign hit   = t_sat >= TIMER_W'(thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		q_ready  = 1'b0;
		emit     = 1'b0;
		e_kind   = KIND_DRAW;
		e_draw   = 1'b0;
		e_color  = '0;
		e_last   = 1'b0;
		adv      = 1'b0;
		tick_adv = 1'b0;
		np_load  = 1'b0;
		np_val   = 1'b0;
		clr_anim = 1'b0;
		set_anim = 1'b0;
		set_pend = 1'b0;
		clr_pend = 1'b0;
		set_tog  = 1'b0;
		wr       = '0;
		case (state_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					case (q_cmd.op)
						OP_SET, OP_BLINK: begin
							state_d = anim_q ? ST_STOP : ST_DRAW;
							np_load = 1'b1;
							np_val  = (q_cmd.op == OP_BLINK) || anim_q;
						end
						OP_TICK: state_d = anim_q ? ST_IDLE : ST_TICK;
						OP_ANIM: state_d = ST_START;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_STOP: begin
				emit   = 1'b1;
				e_kind = KIND_STOP;
				if (emit_ok) begin
					clr_anim = 1'b1;
					state_d  = ST_DRAW;
				end
			end
			ST_DRAW: begin
				emit    = 1'b1;
				e_draw  = 1'b1;
				e_color = cmd_q.color;
				e_last  = last_slot && !need_push_q;
				if (emit_ok) begin
					if (cmd_q.op == OP_SET) begin
						wr.we_rest = 1'b1;
						set_pend   = !need_push_q;
					end else begin
						wr.we_mode  = 1'b1;
						wr.mode     = cmd_q.mode;
						wr.we_phase = 1'b1;
						wr.phase    = 1'b1;
						wr.we_timer = 1'b1;
						wr.we_blnk  = 1'b1;
					end
					if (need_push_q) begin
						state_d = ST_PUSH;
					end else if (last_slot) begin
						state_d = ST_IDLE;
					end else begin
						adv     = 1'b1;
						np_load = 1'b1;
						np_val  = cmd_q.op == OP_BLINK;
					end
				end
			end
			ST_PUSH: begin
				emit   = 1'b1;
				e_kind = KIND_PUSH;
				e_last = last_slot;
				if (emit_ok) begin
					if (last_slot) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_DRAW;
						adv     = 1'b1;
						np_load = 1'b1;
						np_val  = cmd_q.op == OP_BLINK;
					end
				end
			end
			ST_START: begin
				emit   = 1'b1;
				e_kind = KIND_START;
				e_last = 1'b1;
				if (emit_ok) begin
					set_anim = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_TICK: begin
				if (mode_q[cur] == MODE_SOLID) begin
					tick_adv = 1'b1;
				end else if (!hit) begin
					wr.we_timer = 1'b1;
					wr.timer    = t_sat;
					tick_adv    = 1'b1;
				end else begin
					emit   = 1'b1;
					e_draw = 1'b1;
					if (phase_q[cur]) begin
						e_color = '0;
					end else if (mode_q[cur] == MODE_ONCE) begin
						e_color = rest_q[cur];
					end else begin
						e_color = blnk_q[cur];
					end
					if (emit_ok) begin
						wr.we_timer = 1'b1;
						set_tog     = 1'b1;
						if (phase_q[cur]) begin
							wr.we_phase = 1'b1;
							tick_adv    = 1'b1;
						end else begin
							case (mode_q[cur])
								MODE_ONCE: begin
									wr.we_mode = 1'b1;
									wr.mode    = MODE_SOLID;
									tick_adv   = 1'b1;
								end
								MODE_TWICE: begin
									// A double blink restarts as a single one.
									wr.we_mode  = 1'b1;
									wr.mode     = MODE_ONCE;
									wr.we_phase = 1'b1;
									wr.phase    = 1'b1;
									state_d     = ST_TPUSH;
								end
								default: begin
									wr.we_phase = 1'b1;
									wr.phase    = 1'b1;
									tick_adv    = 1'b1;
								end
							endcase
						end
					end
				end
			end
			ST_TPUSH: begin
				emit   = 1'b1;
				e_kind = KIND_PUSH;
				if (emit_ok) begin
					tick_adv = 1'b1;
				end
			end
			ST_TFIN: begin
				if (toggled_q || pend_q) begin
					emit   = 1'b1;
					e_kind = KIND_PUSH;
					e_last = 1'b1;
					if (emit_ok) begin
						clr_pend = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (tick_adv) begin
			if (last_slot) begin
				state_d = ST_TFIN;
			end else begin
				state_d = ST_TICK;
				adv     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			need_push_q <= 1'b0;
			toggled_q   <= 1'b0;
			anim_q      <= 1'b0;
			pend_q      <= 1'b0;
			thr_q       <= THR_W'(BLINK_MS_RESET * THR_SCALE);
		end else begin
			if (pop) begin
				idx_q     <= q_cmd.lo;
				toggled_q <= 1'b0;
			end else begin
				if (adv) begin
					idx_q <= idx_q + 1'b1;
				end
				if (set_tog) begin
					toggled_q <= 1'b1;
				end
			end
			if (np_load) begin
				need_push_q <= np_val;
			end
			if (set_anim) begin
				anim_q <= 1'b1;
			end else if (clr_anim) begin
				anim_q <= 1'b0;
			end
			if (set_pend) begin
				pend_q <= 1'b1;
			end else if (clr_pend) begin
				pend_q <= 1'b0;
			end
			if (cfg_we) begin
				thr_q <= THR_W'(THR_W'(cfg_wdata) * THR_W'(THR_SCALE));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				mode_q[i]  <= MODE_SOLID;
				phase_q[i] <= 1'b0;
				timer_q[i] <= '0;
				rest_q[i]  <= '0;
				blnk_q[i]  <= '0;
			end
		end else begin
			if (wr.we_mode) begin
				mode_q[cur] <= wr.mode;
			end
			if (wr.we_phase) begin
				phase_q[cur] <= wr.phase;
			end
			if (wr.we_timer) begin
				timer_q[cur] <= wr.timer;
			end
			if (wr.we_rest) begin
				rest_q[cur] <= cmd_q.color;
			end
			if (wr.we_blnk) begin
				blnk_q[cur] <= cmd_q.color;
			end
		end
	end

	// The output register lets the sequencer run on while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit && emit_ok) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && emit_ok) begin
			res_kind_q  <= e_kind;
			res_slot_q  <= e_draw ? idx_q[2:0] : 3'd0;
			res_color_q <= e_color;
			res_last_q  <= e_last;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.kind        = res_kind_q;
	assign result.pixel_slot  = res_slot_q;
	assign result.pixel_color = res_color_q;
	assign result.last        = res_last_q;

	a_nondraw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_kind_q != KIND_DRAW) |-> (res_color_q == '0 && res_slot_q == '0))
		else $error("non-draw result carries a slot or a color");

	a_tick_no_anim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK || state_q == ST_TPUSH) |-> !anim_q)
		else $error("tick walks the slots while an animation runs");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (idx_q <= LAST_IDX))
		else $error("slot index beyond the last slot");

	a_start_sets_anim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_START && emit_ok) |=> anim_q)
		else $error("start animation did not enter animation mode");

endmodule

@@ design/multi_slot_led_blink_controller_unit.sv @@
// ----------------------------------------------------------------------------
// Multi-slot LED blink controller
// Commands go through a decoder and a two-entry queue to a slot sequencer that
// issues at most one result per cycle through an output register. The
// sequencer takes one command at a time, taking it from the queue in its idle
// state. After that, a start animation issues its start result, and a set
// color or blink issues a stop result first if an animation runs, then a draw
// result for each addressed slot, each followed by a push result where one is
// due. A tick visits every slot in turn, a toggle draw included, issues a push
// for each restart of a double blink and ends in a final push state, whether
// or not a push is due; a tick in animation mode ends with the take. Stalls on
// the result channel hold the sequencer while a result waits. The decoder
// drops unused codes and out-of-range slots and keeps accepting commands while
// the queue has room.
// ----------------------------------------------------------------------------
module multi_slot_led_blink_controller_unit import msled_pkg::*; #(
	parameter int NUM_SLOTS = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	msled_item_if.sink     item,
	msled_result_if.source result,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata
);

	logic f_valid;
	logic f_ready;
	cmd_t f_cmd;
	logic b_valid;
	logic b_ready;
	cmd_t b_cmd;

	msled_front #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	msled_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_cmd   (f_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_cmd    (b_cmd)
	);

	msled_back #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (b_valid),
		.q_ready   (b_ready),
		.q_cmd     (b_cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

endmodule
